### sv/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// shared types and character codes for the lidar frame parser
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int unsigned VAL_W = 31;

    localparam logic [7:0] CH_Y = 8'h59;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_Y1,
        PH_YY,
        PH_DIST,
        PH_TSEEN,
        PH_TIME
    } t_phase;

    typedef logic [VAL_W-1:0] t_val;

endpackage

### sv/lfp_accum.sv
// ----------------------------------------------------------------------------
// lfp_accum
// decimal multiply-add of one digit, saturating at the 31-bit maximum
// ----------------------------------------------------------------------------
module lfp_accum (
    input  lfp_pkg::t_val i_acc,
    input  logic [3:0]    i_digit,
    output lfp_pkg::t_val o_sum,
    output logic          o_ovf
);

    localparam int unsigned WIDE_W = lfp_pkg::VAL_W + 4;

    logic [WIDE_W-1:0] wide;

    // acc*10 as (acc<<3)+(acc<<1)
    assign wide = ({4'b0, i_acc} << 3) + ({4'b0, i_acc} << 1)
                + {{(WIDE_W-4){1'b0}}, i_digit};

    assign o_ovf = |wide[WIDE_W-1:lfp_pkg::VAL_W];
    assign o_sum = o_ovf ? '1 : wide[lfp_pkg::VAL_W-1:0];

endmodule

### sv/lidar_frame_parser.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser
// byte-serial recogniser for YY<digits>T<digits>E frames from a ranging sensor
// ----------------------------------------------------------------------------
// a reading appears on o_valid in the cycle after its 'E' byte is taken
// throughput: one byte per cycle; the path is one decimal multiply-add and compare
// o_ready drops only while a reading waits and the output side stalls
// reset (synchronous, active low) clears the parser, o_valid and the device id
// ----------------------------------------------------------------------------
module lidar_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [30:0]           o_distance,
    output logic [30:0]           o_time_value,
    output logic                  o_device
);

    lfp_pkg::t_phase r_phase, n_phase;
    lfp_pkg::t_val   r_dist, n_dist;
    lfp_pkg::t_val   r_time, n_time;
    logic            r_ovf, n_ovf;
    logic            r_device_id;

    logic            r_out_valid;
    lfp_pkg::t_val   r_out_dist;
    lfp_pkg::t_val   r_out_time;
    logic            r_out_dev;

    logic            accept;
    logic            emit;
    logic            is_digit;
    lfp_pkg::t_val   acc_in;
    lfp_pkg::t_val   acc_sum;
    logic            acc_ovf;

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_digit = (i_rx_byte >= lfp_pkg::CH_0) && (i_rx_byte <= lfp_pkg::CH_9);
    assign acc_in   = (r_phase == lfp_pkg::PH_TIME) ? r_time : r_dist;

    lfp_accum u_accum (
        .i_acc   (acc_in),
        .i_digit (i_rx_byte[3:0]),
        .o_sum   (acc_sum),
        .o_ovf   (acc_ovf)
    );

    always_comb begin
        n_phase = r_phase;
        n_dist  = r_dist;
        n_time  = r_time;
        n_ovf   = r_ovf;
        emit    = 1'b0;
        if (i_rx_byte == lfp_pkg::CH_E) begin
            emit    = (r_phase == lfp_pkg::PH_TIME) && !r_ovf;
            n_phase = lfp_pkg::PH_IDLE;
            n_dist  = '0;
            n_time  = '0;
            n_ovf   = 1'b0;
        end else if (i_rx_byte == lfp_pkg::CH_Y) begin
            n_phase = (r_phase == lfp_pkg::PH_Y1 || r_phase == lfp_pkg::PH_YY)
                    ? lfp_pkg::PH_YY : lfp_pkg::PH_Y1;
        end else if (is_digit) begin
            unique case (r_phase)
                lfp_pkg::PH_YY: begin
                    n_ovf   = 1'b0;
                    n_dist  = {{(lfp_pkg::VAL_W-4){1'b0}}, i_rx_byte[3:0]};
                    n_time  = '0;
                    n_phase = lfp_pkg::PH_DIST;
                end
                lfp_pkg::PH_DIST: begin
                    n_dist = acc_sum;
                    n_ovf  = r_ovf || acc_ovf;
                end
                lfp_pkg::PH_TSEEN: begin
                    n_time  = {{(lfp_pkg::VAL_W-4){1'b0}}, i_rx_byte[3:0]};
                    n_phase = lfp_pkg::PH_TIME;
                end
                lfp_pkg::PH_TIME: begin
                    n_time = acc_sum;
                    n_ovf  = r_ovf || acc_ovf;
                end
                default: begin
                    n_phase = lfp_pkg::PH_IDLE;
                end
            endcase
        end else if (i_rx_byte == lfp_pkg::CH_T) begin
            n_phase = (r_phase == lfp_pkg::PH_DIST) ? lfp_pkg::PH_TSEEN : lfp_pkg::PH_IDLE;
        end else begin
            n_phase = lfp_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lfp_pkg::PH_IDLE;
            r_dist      <= '0;
            r_time      <= '0;
            r_ovf       <= 1'b0;
            r_device_id <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_device_id <= i_cfg_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_dist  <= n_dist;
                r_time  <= n_time;
                r_ovf   <= n_ovf;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each reading
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_dist <= r_dist;
            r_out_time <= r_time;
            r_out_dev  <= r_device_id;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_distance   = r_out_dist;
    assign o_time_value = r_out_time;
    assign o_device     = r_out_dev;

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx_byte == lfp_pkg::CH_E) |=> (r_phase == lfp_pkg::PH_IDLE && !r_ovf))
        else $error("parser not idle after end of message");

    a_good_frame_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx_byte == lfp_pkg::CH_E && r_phase == lfp_pkg::PH_TIME && !r_ovf)
        |=> r_out_valid)
        else $error("complete frame produced no reading");

    a_new_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_digit && r_phase == lfp_pkg::PH_YY)
        |=> (r_phase == lfp_pkg::PH_DIST && !r_ovf))
        else $error("distance start did not clear overflow");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_dist)))
        else $error("pending reading lost");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the lidar frame parser byte by byte against a behavioural mirror of
// its pattern matcher: directed frames, broken patterns and number limits,
// then random frames and noise under random stalls on both sides, a long
// output stall and both device id settings
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            HOLD_LEN       = 300;
    localparam int            WATCHDOG_LIMIT = 4000;
    localparam int            MAX_REPORTS    = 10;
    localparam lfp_pkg::t_val VAL_MAX        = '1;

    typedef struct packed {
        lfp_pkg::t_val distance;
        lfp_pkg::t_val time_value;
        logic          device;
    } t_reading;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_rx_byte  = 8'h00;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [30:0] o_distance;
    logic [30:0] o_time_value;
    logic        o_device;

    // mirror of the parser state
    lfp_pkg::t_phase mir_phase = lfp_pkg::PH_IDLE;
    lfp_pkg::t_val   mir_dist  = '0;
    lfp_pkg::t_val   mir_time  = '0;
    bit              mir_ovf   = 1'b0;
    logic            mir_dev   = 1'b0;

    t_reading    readings_due[$];
    logic [7:0]  frame_q[$];
    int          errors        = 0;
    int          bytes_sent    = 0;
    int          readings_seen = 0;
    int          idle_cycles   = 0;
    int          stall_left    = 0;
    bit          hold_req      = 1'b0;
    bit          quiet         = 1'b0;

    lidar_frame_parser DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_distance   (o_distance),
        .o_time_value (o_time_value),
        .o_device     (o_device)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'($urandom_range(0, 255));
        if (r < 55) return lfp_pkg::CH_Y;
        if (r < 70) return lfp_pkg::CH_T;
        if (r < 85) return lfp_pkg::CH_0 + 8'($urandom_range(0, 9));
        if (r < 93) return lfp_pkg::CH_E;
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 75) return $urandom_range(1, 4);
        if (r < 92) return $urandom_range(5, 9);
        return $urandom_range(10, 11);
    endfunction

    // decimal multiply-add, saturating at the 31-bit ceiling
    function automatic lfp_pkg::t_val mul_add(input lfp_pkg::t_val acc, input logic [3:0] d,
                                              output bit sat);
        logic [63:0] v;
        v   = 64'(acc) * 64'd10 + 64'(d);
        sat = (v > 64'(VAL_MAX));
        return sat ? VAL_MAX : v[30:0];
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        bit         sat;
        logic [3:0] d;
        sat = 1'b0;
        d   = 4'(b - lfp_pkg::CH_0);
        if (b == lfp_pkg::CH_E) begin
            if (mir_phase == lfp_pkg::PH_TIME && !mir_ovf)
                readings_due.push_back(t_reading'{mir_dist, mir_time, mir_dev});
            mir_phase = lfp_pkg::PH_IDLE;
            mir_dist  = '0;
            mir_time  = '0;
            mir_ovf   = 1'b0;
        end else if (b == lfp_pkg::CH_Y) begin
            mir_phase = (mir_phase == lfp_pkg::PH_Y1 || mir_phase == lfp_pkg::PH_YY)
                      ? lfp_pkg::PH_YY : lfp_pkg::PH_Y1;
        end else if (b >= lfp_pkg::CH_0 && b <= lfp_pkg::CH_9) begin
            case (mir_phase)
                lfp_pkg::PH_YY: begin
                    mir_ovf   = 1'b0;
                    mir_dist  = lfp_pkg::t_val'(d);
                    mir_time  = '0;
                    mir_phase = lfp_pkg::PH_DIST;
                end
                lfp_pkg::PH_DIST: begin
                    mir_dist = mul_add(mir_dist, d, sat);
                    mir_ovf  = mir_ovf | sat;
                end
                lfp_pkg::PH_TSEEN: begin
                    mir_time  = lfp_pkg::t_val'(d);
                    mir_phase = lfp_pkg::PH_TIME;
                end
                lfp_pkg::PH_TIME: begin
                    mir_time = mul_add(mir_time, d, sat);
                    mir_ovf  = mir_ovf | sat;
                end
                default: mir_phase = lfp_pkg::PH_IDLE;
            endcase
        end else if (b == lfp_pkg::CH_T) begin
            mir_phase = (mir_phase == lfp_pkg::PH_DIST) ? lfp_pkg::PH_TSEEN : lfp_pkg::PH_IDLE;
        end else begin
            mir_phase = lfp_pkg::PH_IDLE;
        end
    endtask

    // valid is left high after the request; the next call or wait_idle decides
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_frame_q();
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) frame_q.push_back(lfp_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_device_id(input logic v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mir_dev     = v;
    endtask

    task automatic build_frame();
        int n_y;
        int r;
        frame_q.delete();
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4)) frame_q.push_back(pick_noise());
        r   = $urandom_range(0, 99);
        n_y = (r < 85) ? $urandom_range(2, 4) : (r < 95) ? 1 : 0;
        repeat (n_y) frame_q.push_back(lfp_pkg::CH_Y);
        add_digits(pick_len());
        frame_q.push_back(($urandom_range(0, 99) < 95) ? lfp_pkg::CH_T : pick_noise());
        add_digits(pick_len());
        frame_q.push_back(lfp_pkg::CH_E);
        // occasional corruption anywhere in the frame
        if ($urandom_range(0, 99) < 10)
            frame_q[$urandom_range(0, frame_q.size() - 1)] = pick_noise();
    endtask

    task automatic test_plain_frames();
        send_text("YY0T0E");
        send_text("YYYY042T007E");
    endtask

    task automatic test_broken_patterns();
        send_byte(8'h00);
        send_byte(8'hff);
        send_text("Y5T1E");
        send_text("YYT3E");
        send_text("YY3TE");
        send_text("YY1T2?E");
        send_text("YY1T2YY3T4E");
    endtask

    task automatic test_number_limits();
        send_text("YY2147483647T2147483647E");
        send_text("YY2147483648T1E");
        send_text("YY1T21474836470E");
        send_text("YY5T5E");
    endtask

    // sink holds off while short frames keep coming, so the input must stall
    task automatic test_output_stall();
        quiet    = 1'b1;
        hold_req = 1'b1;
        repeat (12) begin
            frame_q.delete();
            frame_q.push_back(lfp_pkg::CH_Y);
            frame_q.push_back(lfp_pkg::CH_Y);
            add_digits($urandom_range(1, 3));
            frame_q.push_back(lfp_pkg::CH_T);
            add_digits($urandom_range(1, 3));
            frame_q.push_back(lfp_pkg::CH_E);
            send_frame_q();
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(pick_noise());
                    sent++;
                end
            end else begin
                build_frame();
                send_frame_q();
                sent += frame_q.size();
            end
        end
    endtask

    // sink side: random stalls plus the long hold, counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_LEN;
            end else if (stall_left == 0 && !quiet) begin
                stall_left = pick_gap();
            end
            i_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && i_ready) begin
            readings_seen++;
            if (readings_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected reading: distance %0d time %0d device %0d",
                             o_distance, o_time_value, o_device);
            end else begin
                want = readings_due.pop_front();
                if (o_distance !== want.distance || o_time_value !== want.time_value ||
                    o_device !== want.device) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("reading mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.distance, want.time_value, want.device,
                                 o_distance, o_time_value, o_device);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_frames();
        wait_idle();
        set_device_id(1'b1);
        test_broken_patterns();
        test_number_limits();
        wait_idle();
        set_device_id(1'b0);
        test_output_stall();

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            set_device_id(p % 2 == 0);
            quiet = (p == 2);
            test_random_traffic(360);
            quiet = 1'b0;
        end
        wait_idle();

        $display("summary: %0d bytes sent, %0d readings checked", bytes_sent, readings_seen);
        $display("summary: frames, broken and overflowing numbers, both device ids, long stall");
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
